/* rtl/mhkc_pkg.sv */
// Shared types, sizes and the keyword table for the message header classifier.
// Used by mhkc_front, mhkc_queue, mhkc_back and the top level.
package mhkc_pkg;

  // Header buffer size and derived widths
  localparam int HEADER_BUFFER_CHARS = 14;
  localparam int HDR_W   = 8 * HEADER_BUFFER_CHARS;
  localparam int LEN_W   = $clog2(HEADER_BUFFER_CHARS + 1);
  localparam int IDX_W   = $clog2(HEADER_BUFFER_CHARS);
  localparam int KIND_W  = 6;
  localparam int KW_COUNT = 40;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  // Special byte codes
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_NUL     = 8'd0;

  localparam logic [KIND_W-1:0] KIND_UNKNOWN = '0;

  // Keyword text, right-justified as string literals; first char is highest byte
  localparam logic [HDR_W-1:0] KW_RAW [KW_COUNT] = '{
    "CM", "MC", "MX", "PU", "PM", "PO", "PS", "LS", "PE", "FX",
    "HX", "LN", "CU", "CX", "CS", "NM", "AP", "AD", "DY", "HE",
    "MN", "GV", "GM", "GO", "OW", "VS", "FD", "VU", "PH", "PONG",
    "SHUTDOWN", {"SERVER_", "FULL"}, "SN", "ACCEPTED", "REJECTED",
    {"NO_LIFE_", "TOKENS"}, "SD", "MS", "FL", "CR"
  };

  localparam int KW_LEN [KW_COUNT] = '{
    2, 2, 2, 2, 2, 2, 2, 2, 2, 2,
    2, 2, 2, 2, 2, 2, 2, 2, 2, 2,
    2, 2, 2, 2, 2, 2, 2, 2, 2, 4,
    8, 11, 2, 8, 8,
    14, 2, 2, 2, 2
  };

  // One closed header (or message end) handed from front to back
  typedef struct packed {
    logic [HDR_W-1:0] text;     // char i at bits [HDR_W-1-8*i -: 8], zero padded
    logic [LEN_W-1:0] len;
    logic             too_long;
    logic             newline;  // 0: message ended without newline
  } hdr_entry_t;

  // Exact match against the table; first char of the header is the top byte
  function automatic logic [KIND_W-1:0] classify(hdr_entry_t e);
    logic [KIND_W-1:0] kind;
    logic [HDR_W-1:0]  kw;
    kind = KIND_UNKNOWN;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      kw = KW_RAW[k] << (8 * (HEADER_BUFFER_CHARS - KW_LEN[k]));
      if (e.text == kw && e.len == LEN_W'(KW_LEN[k])) begin
        kind = KIND_W'(k + 1);
      end
    end
    if (e.too_long || !e.newline) begin
      kind = KIND_UNKNOWN;
    end
    return kind;
  endfunction

endpackage

/* rtl/message_header_keyword_classifier_top.sv */
// Message header keyword classifier.
// One byte per input transfer (byte_in, end_of_message) on a valid/ready channel.
// The bytes before the first newline form the header; at that newline one result
// gives the keyword code (1..40) or 0 for unknown, with newline_found = 1.
// A header over 14 characters gives 0. A message that ends (end_of_message or a
// zero byte) while the header is still open gives 0 with newline_found = 0.
// Bytes after the newline give no result; the message end clears the header.
// Throughput: one byte per cycle while the queue is not full (in_ready high).
// The entry enters the queue at the transfer of the byte that causes it; the
// keyword compare then loads the output register from the queue head once free.
// A two-entry queue sits between front and back; when the receiver stalls the
// output register holds its result, the queue fills, and in_ready drops only
// once both queue entries are taken.
// Reset (rst, synchronous) clears the header, the queue and the output valid.
// Depends on mhkc_pkg, mhkc_front, mhkc_queue, mhkc_back.
module message_header_keyword_classifier_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  byte_in,
  input  logic                        end_of_message,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mhkc_pkg::KIND_W-1:0] message_kind,
  output logic                        newline_found
);

  mhkc_pkg::hdr_entry_t push_data;
  mhkc_pkg::hdr_entry_t head;
  logic push;
  logic pop;
  logic queue_full;
  logic queue_empty;

  mhkc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .byte_in        (byte_in),
    .end_of_message (end_of_message),
    .queue_full     (queue_full),
    .push           (push),
    .push_data      (push_data)
  );

  mhkc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (queue_empty)
  );

  mhkc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .queue_empty   (queue_empty),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .message_kind  (message_kind),
    .newline_found (newline_found)
  );

endmodule

/* rtl/mhkc_front.sv */
// Front end: takes message bytes, builds the header, queues one entry per result.
// Depends on mhkc_pkg.
module mhkc_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              byte_in,
  input  logic                    end_of_message,
  input  logic                    queue_full,
  output logic                    push,
  output mhkc_pkg::hdr_entry_t    push_data
);

  logic [7:0]                 chars [mhkc_pkg::HEADER_BUFFER_CHARS];
  logic [mhkc_pkg::LEN_W-1:0] header_length;
  logic                       too_long;
  logic                       header_closed;

  logic accept;
  logic is_newline;
  logic is_nul;
  logic ends;
  logic has_room;

  assign in_ready   = !queue_full;
  assign accept     = in_valid && in_ready;
  assign is_newline = (byte_in == mhkc_pkg::CHAR_NEWLINE);
  assign is_nul     = (byte_in == mhkc_pkg::CHAR_NUL);
  assign ends       = end_of_message || is_nul;
  assign has_room   = (header_length < mhkc_pkg::LEN_W'(mhkc_pkg::HEADER_BUFFER_CHARS));

  // Result entry: at the newline of an open header, or at message end while open
  always_comb begin
    push                = accept && !header_closed && (is_newline || ends);
    push_data.len       = header_length;
    push_data.too_long  = too_long;
    push_data.newline   = is_newline;
    for (int i = 0; i < mhkc_pkg::HEADER_BUFFER_CHARS; i++) begin
      push_data.text[mhkc_pkg::HDR_W-1-8*i -: 8] = chars[i];
    end
  end

  // Header collection; message end clears everything
  always_ff @(posedge clk) begin
    if (rst) begin
      header_length <= '0;
      too_long      <= 1'b0;
      header_closed <= 1'b0;
      for (int i = 0; i < mhkc_pkg::HEADER_BUFFER_CHARS; i++) begin
        chars[i] <= '0;
      end
    end else if (accept) begin
      if (ends) begin
        header_length <= '0;
        too_long      <= 1'b0;
        header_closed <= 1'b0;
        for (int i = 0; i < mhkc_pkg::HEADER_BUFFER_CHARS; i++) begin
          chars[i] <= '0;
        end
      end else if (!header_closed) begin
        if (is_newline) begin
          header_closed <= 1'b1;
        end else if (has_room) begin
          chars[header_length[mhkc_pkg::IDX_W-1:0]] <= byte_in;
          header_length <= header_length + 1'b1;
        end else begin
          too_long <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/mhkc_queue.sv */
// Short queue of header entries between the front and the back.
// Depends on mhkc_pkg.
module mhkc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  mhkc_pkg::hdr_entry_t push_data,
  output logic                 full,
  input  logic                 pop,
  output mhkc_pkg::hdr_entry_t pop_data,
  output logic                 empty
);

  mhkc_pkg::hdr_entry_t        slots [mhkc_pkg::QUEUE_DEPTH];
  logic [mhkc_pkg::QPTR_W-1:0] wr_ptr;
  logic [mhkc_pkg::QPTR_W-1:0] rd_ptr;
  logic [mhkc_pkg::QCNT_W-1:0] count;

  assign full     = (count == mhkc_pkg::QCNT_W'(mhkc_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == mhkc_pkg::QPTR_W'(mhkc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == mhkc_pkg::QPTR_W'(mhkc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/mhkc_back.sv */
// Back end: matches the queued header against the keywords into the output register.
// Depends on mhkc_pkg.
module mhkc_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        queue_empty,
  input  mhkc_pkg::hdr_entry_t        head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mhkc_pkg::KIND_W-1:0] message_kind,
  output logic                        newline_found
);

  // Load whenever the output register is free or its transfer completes now
  assign pop = !queue_empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      message_kind  <= mhkc_pkg::classify(head);
      newline_found <= head.newline;
    end
  end

endmodule
